// ===== design/dbd_pkg.sv =====
// Shared types, widths and calendar tables for the date difference pipeline.
// No dependencies; imported by every module of the block.
package dbd_pkg;

  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned MLEN_W  = 5;

  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for every 12-bit x
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned MUL_W        = 13;
  localparam int unsigned PROD_W       = YEAR_W + MUL_W;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned QUOT_W       = PROD_W - DIV100_SHIFT;

  localparam int unsigned DAYS_COMMON_YEAR = 365;
  localparam int unsigned CENTURY          = 100;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [MLEN_W-1:0]  FEB_LEAP_LEN = MLEN_W'(29);

  // Stage advance enables handed from the pipeline control to the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } dbd_adv_t;

  // Day number of one date and its validity
  typedef struct packed {
    logic [COUNT_W-1:0] num;
    logic               ok;
  } dbd_num_t;

  // Days in the months before month m, common year
  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of month m, common year
  function automatic logic [MLEN_W-1:0] month_length(input logic [MONTH_W-1:0] m);
    logic [MLEN_W-1:0] r;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2:                    r = 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== design/dbd_day_number.sv =====
// Three-stage datapath that turns one Gregorian date into its day number.
// Depends on dbd_pkg; stage enables come from the top-level pipeline control.
module dbd_day_number import dbd_pkg::*; #(
  parameter int unsigned MAX_YEAR = 3000
) (
  input  logic               clk_i,
  input  dbd_adv_t           adv_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DAY_W-1:0]   day_i,
  output dbd_num_t           num_o
);

  // Stage 1: reciprocal products, month tables, range checks
  logic [YEAR_W-1:0]  p_q, y_q;
  logic [MONTH_W-1:0] m_q;
  logic [DAY_W-1:0]   d_q;
  logic [PROD_W-1:0]  pprod_q, yprod_q;
  logic [DOY_W-1:0]   dbm_q;
  logic [MLEN_W-1:0]  mlen_q;
  logic               range_ok_q;

  logic [YEAR_W-1:0] p_d;
  logic              range_ok_d;

  assign p_d        = year_i - YEAR_W'(1);
  assign range_ok_d = (year_i != '0) && (32'(year_i) <= MAX_YEAR) &&
                      (month_i >= MONTH_JAN) && (month_i <= MONTH_DEC) &&
                      (day_i != '0);

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      p_q        <= p_d;
      y_q        <= year_i;
      m_q        <= month_i;
      d_q        <= day_i;
      pprod_q    <= PROD_W'(p_d) * PROD_W'(DIV100_MUL);
      yprod_q    <= PROD_W'(year_i) * PROD_W'(DIV100_MUL);
      dbm_q      <= days_before_month(month_i);
      mlen_q     <= month_length(month_i);
      range_ok_q <= range_ok_d;
    end
  end

  // Stage 2: leap rule, whole-year days, day of year, validity
  logic [QUOT_W-1:0]  qp, qy;
  logic [YEAR_W-1:0]  rem_y;
  logic               leap;
  logic [MLEN_W-1:0]  len;
  logic [COUNT_W-1:0] years_d;
  logic [DOY_W-1:0]   doy_d;
  logic               ok_d;

  assign qp    = pprod_q[PROD_W-1:DIV100_SHIFT];
  assign qy    = yprod_q[PROD_W-1:DIV100_SHIFT];
  assign rem_y = y_q - YEAR_W'(qy) * YEAR_W'(CENTURY);
  assign leap  = (y_q[1:0] == 2'b00) && ((rem_y != '0) || (qy[1:0] == 2'b00));
  assign len   = ((m_q == MONTH_FEB) && leap) ? FEB_LEAP_LEN : mlen_q;
  assign ok_d  = range_ok_q && (d_q <= len);

  assign years_d = COUNT_W'(p_q) * COUNT_W'(DAYS_COMMON_YEAR) + COUNT_W'(p_q[YEAR_W-1:2])
                 - COUNT_W'(qp) + COUNT_W'(qp[QUOT_W-1:2]);
  assign doy_d   = dbm_q + DOY_W'(d_q) + DOY_W'((m_q > MONTH_FEB) && leap);

  logic [COUNT_W-1:0] years_q;
  logic [DOY_W-1:0]   doy_q;
  logic               ok2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      years_q <= years_d;
      doy_q   <= doy_d;
      ok2_q   <= ok_d;
    end
  end

  // Stage 3: sum into the day number
  dbd_num_t num_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      num_q.num <= years_q + COUNT_W'(doy_q);
      num_q.ok  <= ok2_q;
    end
  end

  assign num_o = num_q;

endmodule

// ===== design/days_between_dates.sv =====
// Top level: pipeline control, two day-number datapaths and the compare stage.
// Depends on dbd_pkg and dbd_day_number.
//
// Takes one beat of two dates per cycle and returns the days from the first
// date to the second through three stages of day numbering (reciprocal
// division by 100, leap rule and year sum, final add) and one stage of compare
// and subtract that also serves as the output register. Throughput is one beat
// per clock; stall_i holds the whole pipeline, and empty stages fill while the
// output waits. bad_date_o flags a date out of range, order_error_o a second date
// before the first; day_count_o is zero when either flag is set.
module days_between_dates import dbd_pkg::*; #(
  parameter int unsigned MAX_YEAR = 3000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [YEAR_W-1:0]  first_year_i,
  input  logic [MONTH_W-1:0] first_month_i,
  input  logic [DAY_W-1:0]   first_day_i,
  input  logic [YEAR_W-1:0]  second_year_i,
  input  logic [MONTH_W-1:0] second_month_i,
  input  logic [DAY_W-1:0]   second_day_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [COUNT_W-1:0] day_count_o,
  output logic               bad_date_o,
  output logic               order_error_o
);

  localparam int unsigned STAGES = 4;

  // Advance a stage when it is empty or the next one moves
  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] adv;

  assign adv[STAGES-1] = !valid_q[STAGES-1] || !stall_i;
  for (genvar k = 0; k < STAGES - 1; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  assign stall_o = !adv[0];
  assign valid_o = valid_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= valid_i;
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  dbd_adv_t dp_adv;
  assign dp_adv.s1 = adv[0];
  assign dp_adv.s2 = adv[1];
  assign dp_adv.s3 = adv[2];

  // Day numbers of both dates
  dbd_num_t num_a, num_b;

  dbd_day_number #(.MAX_YEAR(MAX_YEAR)) u_first (
    .clk_i   (clk_i),
    .adv_i   (dp_adv),
    .year_i  (first_year_i),
    .month_i (first_month_i),
    .day_i   (first_day_i),
    .num_o   (num_a)
  );

  dbd_day_number #(.MAX_YEAR(MAX_YEAR)) u_second (
    .clk_i   (clk_i),
    .adv_i   (dp_adv),
    .year_i  (second_year_i),
    .month_i (second_month_i),
    .day_i   (second_day_i),
    .num_o   (num_b)
  );

  // Compare, subtract and flag into the output register
  logic               bad_d, order_d;
  logic [COUNT_W-1:0] count_d;
  logic [COUNT_W-1:0] count_q;
  logic               bad_q, order_q;

  assign bad_d   = !(num_a.ok && num_b.ok);
  assign order_d = !bad_d && (num_b.num < num_a.num);
  assign count_d = (bad_d || order_d) ? '0 : (num_b.num - num_a.num);

  always_ff @(posedge clk_i) begin
    if (adv[STAGES-1]) begin
      count_q <= count_d;
      bad_q   <= bad_d;
      order_q <= order_d;
    end
  end

  assign day_count_o   = count_q;
  assign bad_date_o    = bad_q;
  assign order_error_o = order_q;

  // Checks
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (bad_date_o || order_error_o)) |-> (day_count_o == '0))
    else $error("flagged beat carries a nonzero count");

  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(bad_date_o && order_error_o))
    else $error("bad date and order error set together");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> ((&valid_q) && stall_i))
    else $error("input stalled while the pipeline has a free stage");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the days_between_dates pipeline.
// Depends on dbd_pkg and the days_between_dates RTL; nothing else.
`timescale 1ns / 100ps

module tb_top;
  import dbd_pkg::*;

  localparam int unsigned YEAR_LIMIT = 3000;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_PAIRS = 1450;

  typedef struct packed {
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
  } date_t;

  typedef struct packed {
    date_t first;
    date_t second;
  } date_pair_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               bad;
    logic               order;
  } day_span_t;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  logic [YEAR_W-1:0]  first_year_i;
  logic [MONTH_W-1:0] first_month_i;
  logic [DAY_W-1:0]   first_day_i;
  logic [YEAR_W-1:0]  second_year_i;
  logic [MONTH_W-1:0] second_month_i;
  logic [DAY_W-1:0]   second_day_i;
  logic               valid_o;
  logic               stall_i;
  logic [COUNT_W-1:0] day_count_o;
  logic               bad_date_o;
  logic               order_error_o;

  date_pair_t pair_pending [$];
  day_span_t  span_expected [$];
  date_pair_t pair_cur;
  day_span_t  span_want;

  bit pair_taken;
  bit quiet;
  int send_gap;
  int stall_left;
  int cyc;
  int idle_cycles;
  int mismatches;
  int pairs_sent;
  int spans_checked;
  int bad_seen;
  int order_seen;

  days_between_dates #(
    .MAX_YEAR(YEAR_LIMIT)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .first_year_i   (first_year_i),
    .first_month_i  (first_month_i),
    .first_day_i    (first_day_i),
    .second_year_i  (second_year_i),
    .second_month_i (second_month_i),
    .second_day_i   (second_day_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .day_count_o    (day_count_o),
    .bad_date_o     (bad_date_o),
    .order_error_o  (order_error_o)
  );

  // Free-running clock, 2 ns period
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- calendar

  function automatic bit is_leap_year(input int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input bit leap);
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic bit date_is_real(input date_t dt);
    if (dt.y == 0 || dt.y > YEAR_LIMIT) return 1'b0;
    if (dt.m < 1 || dt.m > 12 || dt.d < 1) return 1'b0;
    return dt.d <= month_days(dt.m, is_leap_year(dt.y));
  endfunction

  // Day number of a valid date, 1 January of year 1 is day 1
  function automatic int unsigned day_index(input date_t dt);
    int unsigned p;
    int unsigned n;
    bit          leap;
    p    = dt.y - 1;
    leap = is_leap_year(dt.y);
    n    = 365 * p + p / 4 - p / 100 + p / 400 + dt.d;
    for (int unsigned k = 1; k < dt.m; k++) n += month_days(k, leap);
    return n;
  endfunction

  function automatic day_span_t predict_span(input date_pair_t pr);
    day_span_t   s;
    int unsigned n1;
    int unsigned n2;
    s = '0;
    if (!date_is_real(pr.first) || !date_is_real(pr.second)) begin
      s.bad = 1'b1;
    end else begin
      n1 = day_index(pr.first);
      n2 = day_index(pr.second);
      if (n2 < n1) s.order = 1'b1;
      else s.count = COUNT_W'(n2 - n1);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic date_t make_date(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
    date_t dt;
    dt.y = YEAR_W'(y);
    dt.m = MONTH_W'(m);
    dt.d = DAY_W'(d);
    return dt;
  endfunction

  function automatic date_t rand_date_in_year(input int unsigned y);
    int unsigned m;
    int unsigned len;
    m   = $urandom_range(1, 12);
    len = month_days(m, is_leap_year(y));
    if ($urandom_range(0, 4) == 0) return make_date(y, m, len);
    return make_date(y, m, $urandom_range(1, len));
  endfunction

  // Valid year with extra weight on edge years
  function automatic int unsigned rand_year();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 1 : YEAR_LIMIT;
      1:       return 100 * $urandom_range(1, YEAR_LIMIT / 100);
      2:       return 4 * $urandom_range(1, YEAR_LIMIT / 4);
      default: return $urandom_range(1, YEAR_LIMIT);
    endcase
  endfunction

  // Full-width random bits in every field
  function automatic date_t rand_raw_date();
    date_t dt;
    dt.y = YEAR_W'($urandom);
    dt.m = MONTH_W'($urandom);
    dt.d = DAY_W'($urandom);
    return dt;
  endfunction

  task automatic push_pair(input int unsigned y1, input int unsigned m1, input int unsigned d1,
                           input int unsigned y2, input int unsigned m2, input int unsigned d2);
    date_pair_t pr;
    pr.first  = make_date(y1, m1, d1);
    pr.second = make_date(y2, m2, d2);
    pair_pending.push_back(pr);
  endtask

  task automatic fill_directed();
    push_pair(1, 1, 1, 1, 1, 1);             // equal dates at the bottom
    push_pair(1, 1, 1, 3000, 12, 31);        // widest span
    push_pair(3000, 12, 31, 3000, 12, 31);   // equal dates at the top
    push_pair(3000, 12, 31, 1, 1, 1);        // second date earlier
    push_pair(2020, 5, 2, 2020, 5, 1);       // one day backwards
    push_pair(2000, 2, 28, 2000, 3, 1);      // 400-year leap day
    push_pair(2000, 2, 29, 2000, 2, 29);
    push_pair(1900, 2, 28, 1900, 2, 29);     // century year not leap
    push_pair(2004, 2, 29, 2005, 2, 28);
    push_pair(2001, 2, 29, 2002, 1, 1);      // Feb 29 in common year
    push_pair(2010, 4, 31, 2011, 1, 1);      // day past month end
    push_pair(2010, 1, 1, 2010, 6, 31);
    push_pair(2010, 0, 10, 2011, 1, 1);      // month zero
    push_pair(2010, 1, 1, 2011, 13, 1);      // month above twelve
    push_pair(2010, 15, 31, 2011, 1, 1);
    push_pair(2010, 1, 0, 2011, 1, 1);       // day zero
    push_pair(0, 1, 1, 5, 1, 1);             // year zero
    push_pair(1, 1, 1, 3001, 1, 1);          // year above limit
    push_pair(4095, 15, 31, 4095, 15, 31);
    push_pair(1999, 12, 31, 2000, 1, 1);     // year rollover
    push_pair(1899, 3, 1, 1901, 3, 1);
    push_pair(2024, 3, 1, 2024, 2, 28);      // backwards across leap day
    push_pair(2400, 12, 31, 2401, 1, 1);
    push_pair(2010, 0, 0, 2009, 1, 1);       // invalid and out of order
  endtask

  task automatic fill_random();
    date_pair_t pr;
    date_pair_t tmp;
    int         r;
    int unsigned y;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      r = $urandom_range(0, 99);
      pr.first  = rand_date_in_year(rand_year());
      pr.second = rand_date_in_year(rand_year());
      if (r < 12) begin
        // pure noise
        pr.first  = rand_raw_date();
        pr.second = rand_raw_date();
      end else if (r < 20) begin
        // one field broken in an otherwise sane pair
        tmp = pr;
        case ($urandom_range(0, 5))
          0: tmp.first.y  = YEAR_W'($urandom);
          1: tmp.first.m  = MONTH_W'($urandom);
          2: tmp.first.d  = DAY_W'($urandom);
          3: tmp.second.y = YEAR_W'($urandom);
          4: tmp.second.m = MONTH_W'($urandom);
          default: tmp.second.d = DAY_W'($urandom);
        endcase
        pr = tmp;
      end else if (r < 25) begin
        pr.second = pr.first;
      end else if (r < 45) begin
        // short spans within a year or across one boundary
        y = pr.first.y;
        if (y < YEAR_LIMIT && $urandom_range(0, 1)) y = y + 1;
        pr.second = rand_date_in_year(y);
      end
      // keep most valid pairs in order
      if (r >= 20 && r < 85 && date_is_real(pr.first) && date_is_real(pr.second) &&
          day_index(pr.second) < day_index(pr.first)) begin
        tmp.first  = pr.second;
        tmp.second = pr.first;
        pr = tmp;
      end
      pair_pending.push_back(pr);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (valid_i && !stall_o) begin
        pair_cur.first  = make_date(first_year_i, first_month_i, first_day_i);
        pair_cur.second = make_date(second_year_i, second_month_i, second_day_i);
        span_expected.push_back(predict_span(pair_cur));
        pair_taken = 1'b1;
        pairs_sent++;
        idle_cycles = 0;
      end
      if (valid_o && !stall_i) begin
        idle_cycles = 0;
        if (span_expected.size() == 0) begin
          report_mismatch("unexpected result, day_count", day_count_o, 0);
        end else begin
          span_want = span_expected.pop_front();
          if (day_count_o !== span_want.count)
            report_mismatch("day_count", day_count_o, span_want.count);
          if (bad_date_o !== span_want.bad)
            report_mismatch("bad_date", bad_date_o, span_want.bad);
          if (order_error_o !== span_want.order)
            report_mismatch("order_error", order_error_o, span_want.order);
          if (span_want.bad) bad_seen++;
          if (span_want.order) order_seen++;
          spans_checked++;
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles with no beat", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // Drive input beats and output stall at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      cyc++;
      if (cyc % 300 == 0) quiet = ($urandom_range(0, 3) == 0);

      // advance only once the held beat has gone in
      if (!valid_i || pair_taken) begin
        if (send_gap > 0) begin
          valid_i  <= 1'b0;
          send_gap = send_gap - 1;
        end else if (pair_pending.size() > 0) begin
          pair_cur = pair_pending.pop_front();
          valid_i        <= 1'b1;
          first_year_i   <= pair_cur.first.y;
          first_month_i  <= pair_cur.first.m;
          first_day_i    <= pair_cur.first.d;
          second_year_i  <= pair_cur.second.y;
          second_month_i <= pair_cur.second.m;
          second_day_i   <= pair_cur.second.d;
          send_gap = quiet ? 0 : pick_gap();
        end else begin
          valid_i <= 1'b0;
        end
      end
      pair_taken = 1'b0;

      // hold the output side for random stretches
      if (stall_left > 0) begin
        stall_i    <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        stall_i    <= 1'b0;
        stall_left = quiet ? 0 : pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni         = 1'b0;
    valid_i        = 1'b0;
    stall_i        = 1'b0;
    first_year_i   = '0;
    first_month_i  = '0;
    first_day_i    = '0;
    second_year_i  = '0;
    second_month_i = '0;
    second_day_i   = '0;
    pair_taken     = 1'b0;
    quiet          = 1'b0;
    send_gap       = 0;
    stall_left     = 0;
    cyc            = 0;
    idle_cycles    = 0;
    mismatches     = 0;
    pairs_sent     = 0;
    spans_checked  = 0;
    bad_seen       = 0;
    order_seen     = 0;

    fill_directed();
    fill_random();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain: all beats in, all results out, then let the pipeline settle
    while (pair_pending.size() != 0 || valid_i) @(posedge clk_i);
    while (span_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d date pairs, %0d results checked", pairs_sent, spans_checked);
    $display("%0d with an invalid date, %0d out of order", bad_seen, order_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== days_between_dates.f =====
design/dbd_pkg.sv
design/dbd_day_number.sv
design/days_between_dates.sv
sim/tb_top.sv
